// ===== rtl/core/winograd_output_transform_bn_relu_defines.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef WINOGRAD_OUTPUT_TRANSFORM_BN_RELU_DEFINES_SVH
`define WINOGRAD_OUTPUT_TRANSFORM_BN_RELU_DEFINES_SVH

// same-cycle implication
`define WOTB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WOTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wotb_pkg.sv =====
package wotb_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int ACC_W      = 34;
    localparam int WIDE_W     = 64;
    localparam int IN_W       = 9 * 32;
    localparam int OUT_W      = 4 * 32;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_BIAS_EN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BN_EN   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RELU_EN = 2'd2;

    typedef struct packed {
        logic bias_en;
        logic bn_en;
        logic relu_en;
    } wotb_cfg_t;

    // one finished tile: both partial rows plus the channel values
    typedef struct packed {
        logic [3:0][ACC_W-1:0] p0;
        logic [3:0][ACC_W-1:0] p1;
        logic [DATA_W-1:0]     bias;
        logic [DATA_W-1:0]     mean;
        logic [DATA_W-1:0]     inv_std;
        logic [DATA_W-1:0]     scale;
        logic [DATA_W-1:0]     shift;
    } wotb_job_t;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -(64'sd1 <<< (DATA_W - 1));

    function automatic logic [DATA_W-1:0] sat_dw(input logic signed [WIDE_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[DATA_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/wotb_fifo.sv =====
module wotb_fifo
    import wotb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== rtl/core/wotb_front.sv =====
module wotb_front
    import wotb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [IN_W-1:0] in_data,
    output logic            job_push,
    output wotb_job_t       job,
    input  logic            job_full
);

    localparam logic [1:0] ROW_FIRST  = 2'd0;
    localparam logic [1:0] ROW_SECOND = 2'd1;
    localparam logic [1:0] ROW_THIRD  = 2'd2;
    localparam logic [1:0] ROW_LAST   = 2'd3;

    logic [1:0]            row_cnt_reg, row_cnt_next;
    logic [3:0][ACC_W-1:0] p0_reg, p0_next;
    logic [3:0][ACC_W-1:0] p1_reg, p1_next;
    logic [3:0][ACC_W-1:0] m;
    logic                  accept;

    // only the closing row of a tile needs room in the queue
    assign in_ready = (row_cnt_reg != ROW_LAST) || !job_full;
    assign accept   = in_valid && in_ready;
    assign job_push = accept && (row_cnt_reg == ROW_LAST);

    always_comb
    begin
        for (int j = 0; j < 4; j++)
            m[j] = ACC_W'($signed(in_data[32*j +: 32]));
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            job.p0[j] = p0_reg[j];
            job.p1[j] = p1_reg[j] - m[j];
        end
        job.bias    = in_data[4*32 +: 32];
        job.mean    = in_data[5*32 +: 32];
        job.inv_std = in_data[6*32 +: 32];
        job.scale   = in_data[7*32 +: 32];
        job.shift   = in_data[8*32 +: 32];
    end

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        p0_next      = p0_reg;
        p1_next      = p1_reg;
        if (accept)
        begin
            row_cnt_next = row_cnt_reg + 1'b1;
            case (row_cnt_reg)
                ROW_FIRST:
                begin
                    p0_next = m;
                    p1_next = '0;
                end
                ROW_SECOND:
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        p0_next[j] = p0_reg[j] + m[j];
                        p1_next[j] = p1_reg[j] + m[j];
                    end
                end
                ROW_THIRD:
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        p0_next[j] = p0_reg[j] + m[j];
                        p1_next[j] = p1_reg[j] - m[j];
                    end
                end
                default:
                begin
                    p0_next = p0_reg;
                    p1_next = p1_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_cnt_reg <= ROW_FIRST;
        else
            row_cnt_reg <= row_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        p0_reg <= p0_next;
        p1_reg <= p1_next;
    end

endmodule

// ===== rtl/core/wotb_back.sv =====
module wotb_back
    import wotb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  wotb_cfg_t        cfg,
    input  logic             job_valid,
    input  wotb_job_t        job,
    output logic             job_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_SUM  = 10'b00_0000_0010,
        ST_BIAS = 10'b00_0000_0100,
        ST_SUB  = 10'b00_0000_1000,
        ST_MULA = 10'b00_0001_0000,
        ST_SATA = 10'b00_0010_0000,
        ST_MULB = 10'b00_0100_0000,
        ST_SATB = 10'b00_1000_0000,
        ST_ADD  = 10'b01_0000_0000,
        ST_HOLD = 10'b10_0000_0000
    } state_t;

    state_t                       state_reg, state_next;
    logic [1:0]                   k_reg, k_next;
    logic signed [DATA_W-1:0]     v_reg, v_next;
    logic signed [2*DATA_W-1:0]   prod_reg, prod_next;
    logic [3:0][DATA_W-1:0]       z_reg, z_next;
    logic                         out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]             out_data_reg, out_data_next;

    logic [3:0][ACC_W-1:0]        xsel;
    logic signed [WIDE_W-1:0]     e0, e1, e2, e3, tsum;
    logic signed [WIDE_W-1:0]     pshift;
    logic signed [DATA_W-1:0]     vfin;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // element k: bit 1 picks the partial row, bit 0 the At row
    always_comb
    begin
        xsel   = k_reg[1] ? job.p1 : job.p0;
        e0     = WIDE_W'($signed(xsel[0]));
        e1     = WIDE_W'($signed(xsel[1]));
        e2     = WIDE_W'($signed(xsel[2]));
        e3     = WIDE_W'($signed(xsel[3]));
        tsum   = k_reg[0] ? (e1 - e2 - e3) : (e0 + e1 + e2);
        pshift = WIDE_W'(prod_reg >>> FRAC_W);
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        v_next         = v_reg;
        prod_next      = prod_reg;
        z_next         = z_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        job_pop        = 1'b0;
        vfin           = v_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    k_next     = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                v_next     = sat_dw(tsum);
                state_next = ST_BIAS;
            end
            ST_BIAS:
            begin
                if (cfg.bias_en)
                    v_next = sat_dw(WIDE_W'(v_reg) + WIDE_W'($signed(job.bias)));
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                if (cfg.bn_en)
                    v_next = sat_dw(WIDE_W'(v_reg) - WIDE_W'($signed(job.mean)));
                state_next = ST_MULA;
            end
            ST_MULA:
            begin
                prod_next  = v_reg * $signed(job.inv_std);
                state_next = ST_SATA;
            end
            ST_SATA:
            begin
                if (cfg.bn_en)
                    v_next = sat_dw(pshift);
                state_next = ST_MULB;
            end
            ST_MULB:
            begin
                prod_next  = v_reg * $signed(job.scale);
                state_next = ST_SATB;
            end
            ST_SATB:
            begin
                if (cfg.bn_en)
                    v_next = sat_dw(pshift);
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (cfg.bn_en)
                    vfin = sat_dw(WIDE_W'(v_reg) + WIDE_W'($signed(job.shift)));
                if (cfg.relu_en && vfin[DATA_W-1])
                    vfin = '0;
                z_next[k_reg] = vfin;
                k_next        = k_reg + 1'b1;
                state_next    = (k_reg == 2'd3) ? ST_HOLD : ST_SUM;
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = z_reg;
                    out_valid_next = 1'b1;
                    job_pop        = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        v_reg        <= v_next;
        prod_reg     <= prod_next;
        z_reg        <= z_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/core/winograd_output_transform_bn_relu.sv =====
// Path: the beat carrying a tile's fourth row pushes the tile into the queue, from which the
// sequencer takes it and registers the result beat. Rows are taken one per cycle while the
// tile queue has room; the post-processing sequencer handles one tile at a time (8 steps for
// each of the four values, one value after another), so a full queue holds off a closing row.
// Reset (rst_n, async, active low): row counter, queue, sequencer and output valid
// cleared; bias, batch norm and ReLU disabled.
`include "winograd_output_transform_bn_relu_defines.svh"

module winograd_output_transform_bn_relu
    import wotb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic                  cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // col0, col1, col2, col3, bias, mean, inverse_std, scale, shift (32 bits each)
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // z0, z1, z2, z3 (32 bits each)
    output logic [OUT_W-1:0]      m_tdata
);

    wotb_cfg_t cfg_reg, cfg_next;
    wotb_job_t job_in, job_out;
    logic      q_push, q_pop, q_full, q_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_BIAS_EN: cfg_next.bias_en = cfg_wdata;
                REG_BN_EN:   cfg_next.bn_en   = cfg_wdata;
                REG_RELU_EN: cfg_next.relu_en = cfg_wdata;
                default:     cfg_next         = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    wotb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .job_push (q_push),
        .job      (job_in),
        .job_full (q_full)
    );

    wotb_fifo #(
        .WIDTH ($bits(wotb_job_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (job_in),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (job_out),
        .empty (q_empty)
    );

    wotb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (!q_empty),
        .job       (job_out),
        .job_pop   (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    `WOTB_ASSERT_NOW(a_push_room, clk, rst_n, q_push, !q_full, "tile pushed into a full queue")
    `WOTB_ASSERT_NOW(a_pop_data, clk, rst_n, q_pop, !q_empty, "tile popped from an empty queue")
    `WOTB_ASSERT_NEXT(a_pop_out, clk, rst_n, q_pop, m_tvalid, "retired tile produced no result beat")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import wotb_pkg::*;

    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int SETTLE_CYCLES     = 40;
    localparam int HOLD_OFF_CYCLES   = 600;
    localparam int TILES_PER_SETTING = 60;
    localparam int MAX_PRINTS        = 30;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;

    // packed so that col0 lands in the low bits, same as s_tdata
    typedef struct packed {
        logic [DATA_W-1:0] shift;
        logic [DATA_W-1:0] scale;
        logic [DATA_W-1:0] inv_std;
        logic [DATA_W-1:0] mean;
        logic [DATA_W-1:0] bias;
        logic [DATA_W-1:0] col3;
        logic [DATA_W-1:0] col2;
        logic [DATA_W-1:0] col1;
        logic [DATA_W-1:0] col0;
    } tile_row_t;

    typedef struct packed {
        logic [DATA_W-1:0] z3;
        logic [DATA_W-1:0] z2;
        logic [DATA_W-1:0] z1;
        logic [DATA_W-1:0] z0;
    } out_quad_t;

    class bn_relu_scoreboard;
        bit          bias_on;
        bit          bn_on;
        bit          relu_on;
        longint      p0_row [4];
        longint      p1_row [4];
        int unsigned row_in_tile;
        out_quad_t   expected_quads [$];
        int unsigned mismatches;
        int unsigned tiles_checked;

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic v);
            case (idx)
                REG_BIAS_EN: bias_on = v;
                REG_BN_EN:   bn_on = v;
                REG_RELU_EN: relu_on = v;
                default:     ;
            endcase
        endfunction

        function longint sx(logic [DATA_W-1:0] w);
            return longint'($signed(w));
        endfunction

        function longint clip(longint v);
            if (v > SAT_MAX)
                return longint'(SAT_MAX);
            if (v < SAT_MIN)
                return longint'(SAT_MIN);
            return v;
        endfunction

        // operands are already clipped to 32 bits, so the product fits in 64
        function longint fx_mul(longint a, longint b);
            longint p;
            p = a * b;
            return clip(p >>> FRAC_W);
        endfunction

        function longint post_process(longint z, tile_row_t r);
            longint v;
            v = clip(z);
            if (bias_on)
                v = clip(v + sx(r.bias));
            if (bn_on)
            begin
                v = clip(v - sx(r.mean));
                v = fx_mul(v, sx(r.inv_std));
                v = fx_mul(v, sx(r.scale));
                v = clip(v + sx(r.shift));
            end
            if (relu_on && v < 0)
                v = 0;
            return v;
        endfunction

        function void note_row(tile_row_t r);
            longint    m [4];
            longint    z [4];
            out_quad_t q;
            m[0] = sx(r.col0);
            m[1] = sx(r.col1);
            m[2] = sx(r.col2);
            m[3] = sx(r.col3);
            for (int j = 0; j < 4; j++)
            begin
                case (row_in_tile)
                    0:
                    begin
                        p0_row[j] = m[j];
                        p1_row[j] = 0;
                    end
                    1:
                    begin
                        p0_row[j] += m[j];
                        p1_row[j] += m[j];
                    end
                    2:
                    begin
                        p0_row[j] += m[j];
                        p1_row[j] -= m[j];
                    end
                    default: p1_row[j] -= m[j];
                endcase
            end
            if (row_in_tile != 3)
            begin
                row_in_tile++;
                return;
            end
            row_in_tile = 0;
            z[0] = p0_row[0] + p0_row[1] + p0_row[2];
            z[1] = p0_row[1] - p0_row[2] - p0_row[3];
            z[2] = p1_row[0] + p1_row[1] + p1_row[2];
            z[3] = p1_row[1] - p1_row[2] - p1_row[3];
            q.z0 = DATA_W'(post_process(z[0], r));
            q.z1 = DATA_W'(post_process(z[1], r));
            q.z2 = DATA_W'(post_process(z[2], r));
            q.z3 = DATA_W'(post_process(z[3], r));
            expected_quads.push_back(q);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTS)
                $display("[%0t] MISMATCH %s", $time, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("tile %0d %s: got %h want %h",
                                          tiles_checked, name, got, want));
        endtask

        task check_result(out_quad_t got);
            out_quad_t want;
            if (expected_quads.size() == 0)
            begin
                report_mismatch($sformatf("result beat %h with no tile pending", got));
                return;
            end
            want = expected_quads.pop_front();
            check_field("z0", got.z0, want.z0);
            check_field("z1", got.z1, want.z1);
            check_field("z2", got.z2, want.z2);
            check_field("z3", got.z3, want.z3);
            tiles_checked++;
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic                  cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    tile_row_t             s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    out_quad_t             m_tdata;

    bn_relu_scoreboard sb;
    int unsigned       rows_sent;
    int unsigned       idle_cycles;
    int unsigned       burst_left;
    bit                hold_req;
    bit                hold_done;

    winograd_output_transform_bn_relu uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly small Q16.16 values so the normalization path stays in range,
    // with full-range words and the corner values mixed in.
    function automatic logic [DATA_W-1:0] pick_word(bit near_one);
        logic [DATA_W-1:0] w;
        case ($urandom_range(0, 9))
            0, 1: w = $urandom;
            2:
            begin
                case ($urandom_range(0, 4))
                    0:       w = Q_MAX;
                    1:       w = Q_MIN;
                    2:       w = '0;
                    3:       w = '1;
                    default: w = 32'd1;
                endcase
            end
            default:
            begin
                if (near_one)
                begin
                    w = Q_ONE + $urandom_range(0, 32'h1_0000) - 32'h8000;
                    if ($urandom_range(0, 3) == 0)
                        w = -w;
                end
                else
                    w = $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
            end
        endcase
        return w;
    endfunction

    task automatic send_row(input tile_row_t r);
        int unsigned gap;
        bit          took;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
    endtask

    // row k carries the pattern rotated by k; channel values only count on the last row
    task automatic send_directed_tile(input logic [DATA_W-1:0] a, b, c, d,
                                      input logic [DATA_W-1:0] bias, mean, inv_std,
                                      input logic [DATA_W-1:0] scale, shift);
        logic [DATA_W-1:0] pat [4];
        tile_row_t         r;
        pat = '{a, b, c, d};
        for (int k = 0; k < 4; k++)
        begin
            r.col0 = pat[k];
            r.col1 = pat[(k + 1) % 4];
            r.col2 = pat[(k + 2) % 4];
            r.col3 = pat[(k + 3) % 4];
            if (k == 3)
            begin
                r.bias    = bias;
                r.mean    = mean;
                r.inv_std = inv_std;
                r.scale   = scale;
                r.shift   = shift;
            end
            else
            begin
                r.bias    = pick_word(1'b0);
                r.mean    = pick_word(1'b0);
                r.inv_std = pick_word(1'b1);
                r.scale   = pick_word(1'b1);
                r.shift   = pick_word(1'b0);
            end
            send_row(r);
        end
    endtask

    task automatic send_random_tile();
        tile_row_t r;
        for (int k = 0; k < 4; k++)
        begin
            r.col0    = pick_word(1'b0);
            r.col1    = pick_word(1'b0);
            r.col2    = pick_word(1'b0);
            r.col3    = pick_word(1'b0);
            r.bias    = pick_word(1'b0);
            r.mean    = pick_word(1'b0);
            r.inv_std = pick_word(1'b1);
            r.scale   = pick_word(1'b1);
            r.shift   = pick_word(1'b0);
            send_row(r);
        end
    endtask

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] idx, input logic v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    task automatic write_regs(input bit bias_en, input bit bn_en, input bit relu_en);
        put_reg(REG_UNUSED, 1'($urandom_range(0, 1)));
        put_reg(REG_BIAS_EN, bias_en);
        put_reg(REG_BN_EN, bn_en);
        put_reg(REG_RELU_EN, relu_en);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (sb.expected_quads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // beats are sampled mid-cycle; a beat seen here completes at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (s_tvalid && s_tready)
            begin
                sb.note_row(s_tdata);
                rows_sent++;
            end
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : sink_side
        int unsigned mode;
        int unsigned span;
        int unsigned stalled;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 100);
            for (int c = 0; c < span; c++)
            begin
                @(posedge clk);
                if (hold_req && !hold_done)
                begin
                    m_tready <= 1'b0;
                    stalled = 0;
                    while (stalled < HOLD_OFF_CYCLES)
                    begin
                        @(posedge clk);
                        stalled++;
                    end
                    hold_done = 1'b1;
                    m_tready <= 1'b1;
                end
                else
                begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    initial
    begin : main
        sb          = new();
        rows_sent   = 0;
        idle_cycles = 0;
        burst_left  = 0;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all post-processing off after reset: raw transform and its saturation
        send_directed_tile(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        send_directed_tile(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
        send_directed_tile(Q_MAX, Q_MIN, '0, '1, 32'd1, 32'd1, Q_ONE, Q_ONE, '0);
        s_tvalid <= 1'b0;
        drain();

        // everything on: saturation through bias and norm, floor of negative products, relu
        write_regs(1'b1, 1'b1, 1'b1);
        send_directed_tile(Q_ONE, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000,
                           Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        send_directed_tile(-32'sd3, 32'd5, 32'd1, -32'sd7,
                           32'd1, '0, 32'h0000_8000, 32'hFFFF_0000, '0);
        send_directed_tile(Q_MIN, Q_MIN, Q_MAX, 32'h8000_0001,
                           Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
        s_tvalid <= 1'b0;
        drain();

        for (int setting = 0; setting < 8; setting++)
        begin
            write_regs(setting[0], setting[1], setting[2]);
            if (setting == 3)
                hold_req = 1'b1;
            repeat (TILES_PER_SETTING) send_random_tile();
            s_tvalid <= 1'b0;
            drain();
        end

        $display("%0d rows in, %0d tiles checked, %0d mismatches",
                 rows_sent, sb.tiles_checked, sb.mismatches);
        $display("covered all bias/norm/relu settings, corner values and a %0d-cycle sink stall",
                 HOLD_OFF_CYCLES);
        if (sb.mismatches == 0 && sb.expected_quads.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
